// File: design/prct_pkg.sv
// Shared types and constants of the page reference-count range table.
package prct_pkg;

   // Widths of the request and result fields.
   localparam int OP_W     = 3;
   localparam int ADDR_W   = 48;
   localparam int LEN_W    = 22;
   localparam int ENTRY_W  = 64;
   localparam int STATUS_W = 2;
   localparam int DONE_W   = 10;
   localparam int SIZE_W   = 22;

   // Byte sums of address and length are formed this wide so they never wrap.
   localparam int WIDE_W = 50;

   // Width of the table-slot sum before it is reduced into the table.
   localparam int SUM_W = 24;

   // Configuration register indexes.
   localparam logic REG_REGION_BASE = 1'b0;
   localparam logic REG_REGION_SIZE = 1'b1;

   // Operation codes.
   typedef enum logic [OP_W-1:0] {
      OP_GET     = 3'd0,
      OP_PUT     = 3'd1,
      OP_CLEAR   = 3'd2,
      OP_PRESENT = 3'd3,
      OP_WRITE   = 3'd4
   } op_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_RANGE  = 2'd1,
      ST_ABSENT = 2'd2,
      ST_RETRY  = 2'd3
   } status_type;

   // Entry constants: one reference step, the under-reclaim mark and the saturation limits.
   localparam logic [ENTRY_W-1:0] REF_STEP     = 64'd2;
   localparam logic [ENTRY_W-1:0] RECLAIM_MARK = 64'hFFFF_FFFF_FFFF_FFFE;
   localparam logic [ENTRY_W-1:0] ENTRY_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [DONE_W-1:0]  DONE_MAX     = 10'd1023;

   // Outcome of one entry update.
   typedef struct packed {
      logic [ENTRY_W-1:0] new_entry;
      logic               do_write;
      logic               stop;
      status_type         status;
   } alu_res_type;

endpackage

// File: design/page_refcount_range_table_top.sv
// Steps: range check and slot setup, slot reduction, then a read and an update per page walked
// (an entry write writes its one entry instead), then the result. Out-of-range requests end
// after the range check and unknown operations go straight to the result. One request at a time.
// A new request is taken while the previous result still waits in the output register.
// Reset: synchronous; afterwards a clearing pass zeroes the table, during which no request
// is accepted (configuration writes are taken as usual).
module page_refcount_range_table_top
   import prct_pkg::*;
#(
   parameter int PAGE_BITS     = 12,
   parameter int TABLE_ENTRIES = 1024,
   parameter int ADDR_BITS     = 48
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,   // addr[47:0], len[69:48], entry_value[133:70], zero pad
   input  logic [2:0]   req_tuser,   // op[2:0]
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // status[1:0], pages_done[11:2], zero pad
   // Configuration write channel.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [47:0]  csr_data
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int PN_W  = WIDE_W - PAGE_BITS;
   localparam logic [ADDR_W-1:0] AMASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
      ((48'd1 << (ADDR_BITS % ADDR_W)) - 48'd1);
   localparam logic [WIDE_W-1:0] PB_MASK   = (50'd1 << PAGE_BITS) - 50'd1;
   localparam logic [PN_W-1:0]   SLOT_MASK = PN_W'((64'd1 << (PAGE_BITS - 3)) - 64'd1);
   localparam logic [SUM_W-1:0]  TE_SUM    = SUM_W'(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_WIDEN, S_CHECK, S_SLOT, S_REDUCE, S_WRITE, S_READ, S_UPDATE, S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [ENTRY_W-1:0] val_ff, val_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [WIDE_W-1:0]  start_ff, start_in;
   logic [WIDE_W-1:0]  end_ff, end_in;
   logic [WIDE_W-1:0]  limit_ff, limit_in;
   logic [PN_W-1:0]    page_ff, page_in;
   logic [PN_W-1:0]    stop_ff, stop_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [DONE_W-1:0]  done_ff, done_in;
   status_type         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_data_ff, rsp_data_in;

   logic [ADDR_W-1:0]  base_m;
   logic [PN_W-1:0]    vb;
   logic [WIDE_W-1:0]  len_eff;
   logic               tbl_busy;
   logic               rd_en;
   logic               wr_en;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;
   alu_res_type        alu_res;

   assign base_m = base_ff & AMASK;
   assign vb     = PN_W'({2'b00, base_m} >> PAGE_BITS);

   // An entry write is range-checked as a one-byte range.
   assign len_eff = (op_ff == OP_WRITE) ? 50'd1 : WIDE_W'(len_ff);

   prct_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .busy    (tbl_busy)
   );

   prct_entry_alu u_alu (
      .op    (op_type'(op_ff)),
      .entry (rd_data),
      .res   (alu_res)
   );

   assign req_tready = (state_ff == S_IDLE) && !tbl_busy;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Memory port control.
   assign rd_en   = (state_ff == S_READ);
   assign wr_en   = (state_ff == S_WRITE) || ((state_ff == S_UPDATE) && !alu_res.stop &&
                    alu_res.do_write);
   assign wr_data = (state_ff == S_WRITE) ? val_ff : alu_res.new_entry;

   // Sequencer: range check, slot setup, then one read and one update per page, or one write for an entry write.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      val_in       = val_ff;
      base_in      = base_ff;
      size_in      = size_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      limit_in     = limit_ff;
      page_in      = page_ff;
      stop_in      = stop_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      done_in      = done_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes.
      if (csr_valid) begin
         unique case (csr_index)
            REG_REGION_BASE: base_in = csr_data;
            REG_REGION_SIZE: size_in = csr_data[SIZE_W-1:0];
            default:         base_in = base_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in     = req_tuser;
               addr_in   = req_tdata[47:0] & AMASK;
               len_in    = req_tdata[69:48];
               val_in    = req_tdata[133:70];
               done_in   = '0;
               status_in = ST_OK;
               // Unknown operations complete at once with no effect.
               state_in  = (req_tuser > OP_WRITE) ? S_DONE : S_WIDEN;
            end
         end
         S_WIDEN: begin
            start_in = {2'b00, addr_ff} & ~PB_MASK;
            end_in   = ({2'b00, addr_ff} + len_eff + PB_MASK) & ~PB_MASK;
            limit_in = {2'b00, base_m} + WIDE_W'(size_ff);
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if ((start_ff < {2'b00, base_m}) || (end_ff > limit_ff)) begin
               status_in = ST_RANGE;
               state_in  = S_DONE;
            end else begin
               page_in  = start_ff[WIDE_W-1:PAGE_BITS];
               stop_in  = end_ff[WIDE_W-1:PAGE_BITS];
               state_in = S_SLOT;
            end
         end
         S_SLOT: begin
            sum_in   = SUM_W'(vb & SLOT_MASK) + SUM_W'(page_ff - vb);
            state_in = S_REDUCE;
         end
         S_REDUCE: begin
            // Reduce the slot sum into the table one subtraction at a time.
            if (sum_ff >= TE_SUM) begin
               sum_in = sum_ff - TE_SUM;
            end else begin
               idx_in = sum_ff[IDX_W-1:0];
               if (op_ff == OP_WRITE) begin
                  state_in = S_WRITE;
               end else if (page_ff == stop_ff) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_WRITE: begin
            done_in  = 10'd1;
            state_in = S_DONE;
         end
         S_READ: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (alu_res.stop) begin
               status_in = alu_res.status;
               state_in  = S_DONE;
            end else begin
               if (done_ff != DONE_MAX) begin
                  done_in = done_ff + 1'b1;
               end
               page_in  = page_ff + 1'b1;
               idx_in   = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
               state_in = ((page_ff + 1'b1) == stop_ff) ? S_DONE : S_READ;
            end
         end
         S_DONE: begin
            // Wait for the output register to be free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, done_ff, status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         size_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         size_ff      <= size_in;
      end
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      len_ff      <= len_in;
      val_ff      <= val_in;
      start_ff    <= start_in;
      end_ff      <= end_in;
      limit_ff    <= limit_in;
      page_ff     <= page_in;
      stop_ff     <= stop_in;
      sum_ff      <= sum_in;
      idx_ff      <= idx_in;
      done_ff     <= done_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: design/prct_entry_alu.sv
// Shared entry update unit: one 64-bit adder for get and put, plus the stop checks.
module prct_entry_alu
   import prct_pkg::*;
(
   input  op_type             op,
   input  logic [ENTRY_W-1:0] entry,
   output alu_res_type        res
);

   logic [ENTRY_W-1:0] addend;
   logic [ENTRY_W-1:0] sum;

   // Put adds minus two, every other operation adds two.
   assign addend = (op == OP_PUT) ? (~REF_STEP + 64'd1) : REF_STEP;
   assign sum    = entry + addend;

   // Decode the operation into the new entry and the walk control.
   always_comb begin
      res.new_entry = entry;
      res.do_write  = 1'b0;
      res.stop      = 1'b0;
      res.status    = ST_OK;
      unique case (op)
         OP_GET: begin
            if (entry == RECLAIM_MARK) begin
               res.stop   = 1'b1;
               res.status = ST_RETRY;
            end else begin
               // A saturated count stays as it is.
               res.new_entry = (entry == ENTRY_MAX) ? entry : sum;
               res.do_write  = 1'b1;
            end
         end
         OP_PUT: begin
            res.new_entry = sum;
            res.do_write  = 1'b1;
         end
         OP_CLEAR: begin
            res.new_entry = '0;
            res.do_write  = 1'b1;
         end
         OP_PRESENT: begin
            if (!entry[0]) begin
               res.stop   = 1'b1;
               res.status = ST_ABSENT;
            end
         end
         default: begin
            res.new_entry = entry;
         end
      endcase
   end

endmodule

// File: design/prct_table.sv
// Page entry memory with a registered read port and a clearing pass after reset.
module prct_table
   import prct_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rd_en,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
   output logic [ENTRY_W-1:0]               rd_data,
   input  logic                             wr_en,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
   input  logic [ENTRY_W-1:0]               wr_data,
   output logic                             busy
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
   logic               clr_ff;
   logic               clr_in;
   logic [IDX_W-1:0]   clr_idx_ff;
   logic [IDX_W-1:0]   clr_idx_in;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic [ENTRY_W-1:0] rd_data_ff;

   // The clearing pass walks every entry once, one per cycle.
   always_comb begin
      clr_in     = clr_ff;
      clr_idx_in = clr_idx_ff;
      if (clr_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == LAST_IDX) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_idx_ff <= '0;
      end else begin
         clr_ff     <= clr_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   // The clearing pass owns the write port while it runs.
   assign mem_we    = clr_ff | wr_en;
   assign mem_waddr = clr_ff ? clr_idx_ff : wr_addr;
   assign mem_wdata = clr_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_ff;

endmodule

// File: design/prct_checker.sv
// Port-level checks of the page reference-count range table and their binding.
module prct_checker
   import prct_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A pending result stays until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   // An out-of-range result never reports pages done.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == ST_RANGE) |-> (rsp_tdata[11:2] == 10'd0))
      else $error("out-of-range result with pages done");

   // The block turns busy right after it takes a request.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a request is in work");

   // The clearing pass keeps requests out right after reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("request accepted during the clearing pass");

endmodule

bind page_refcount_range_table_top prct_checker u_prct_checker (.*);
